// ===== sv/dqh_pkg.sv =====
// Shared types, constants and helpers of the DNS query hash responder.
// Used by every module of the block; depends on nothing else.

package dqh_pkg;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned NUM_ACCS  = 3;
  localparam int unsigned HASH_MOD  = 829;
  // 2^10 folded back into the modulus.
  localparam int unsigned FOLD_K    = (1 << 10) % HASH_MOD;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Header byte positions.
  localparam logic [3:0] HDR_QD_HI = 4'd4;
  localparam logic [3:0] HDR_QD_LO = 4'd5;
  localparam logic [3:0] HDR_AN_HI = 4'd6;
  localparam logic [3:0] HDR_AN_LO = 4'd7;
  localparam logic [3:0] HDR_LAST  = 4'd11;

  localparam logic [7:0] ANCOUNT_HI = 8'h00;
  localparam logic [7:0] ANCOUNT_LO = 8'h01;
  localparam logic [7:0] MAX_LABEL  = 8'd63;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [5:0] FIXED_LEN  = 6'd4;

  // Answer record bytes.
  localparam logic [7:0] ANS_PTR_HI = 8'hC0;
  localparam logic [7:0] ANS_PTR_LO = 8'h0C;
  localparam logic [7:0] ANS_ONE    = 8'h01;
  localparam logic [7:0] ANS_ZERO   = 8'h00;
  localparam logic [7:0] ANS_RDLEN  = 8'h04;
  localparam logic [3:0] ANS_LAST   = 4'd15;

  // Finalize sequence steps.
  localparam logic [2:0] FIN_COMB1 = 3'd0;
  localparam logic [2:0] FIN_COMB2 = 3'd3;
  localparam logic [2:0] FIN_DONE  = 3'd6;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN,
    PH_DATA,
    PH_FIXED,
    PH_DROP,
    PH_FINAL
  } phase_e;

  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_CHAR,
    HOP_COMB1,
    HOP_COMB2
  } hash_op_e;

  typedef struct packed {
    hash_op_e   op;
    logic [7:0] ch;
    logic       clr;
  } hash_req_t;

  typedef struct packed {
    logic                         answer;
    logic [7:0]                   data;
    logic                         last;
    logic                         bad;
    logic [NUM_LANES-1:0][7:0]    hash;
  } q_entry_t;

endpackage

// ===== sv/dqh_in_if.sv =====
// Input byte stream channel of the DNS query hash responder.
// Carries valid, ready and one query byte with its end marker.

interface dqh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== sv/dqh_out_if.sv =====
// Output byte stream channel of the DNS query hash responder.
// Carries valid, ready and one response byte with its end and error flags.

interface dqh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       malformed;

  modport source (output valid, output out_byte, output out_last, output malformed,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input malformed,
                  output ready);
endinterface

// ===== sv/dqh_hash.sv =====
// Four-lane modular hash unit: h = h * (c + lane) mod 829 in a three-stage pipeline.
// Depends on dqh_pkg. Three interleaved accumulators per lane are merged on request.

module dqh_hash (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dqh_pkg::hash_req_t                     req_i,
  output logic [dqh_pkg::NUM_LANES-1:0][7:0]     hash_o
);

  logic [9:0]  acc_q [dqh_pkg::NUM_ACCS][dqh_pkg::NUM_LANES];
  logic [1:0]  sel_q, sel_d;

  logic                                   s1_valid_q, s2_valid_q;
  logic [1:0]                             s1_tgt_q, s2_tgt_q, tgt;
  logic [dqh_pkg::NUM_LANES-1:0][19:0]    s1_prod_q;
  logic [dqh_pkg::NUM_LANES-1:0][14:0]    s2_red_q;
  logic [dqh_pkg::NUM_LANES-1:0][9:0]     base, factor, red_out;
  logic [dqh_pkg::NUM_LANES-1:0][14:0]    red_mid;
  logic                                   issue;

  // Operand selection for the multiplier stage.
  always_comb begin
    issue = (req_i.op != dqh_pkg::HOP_NONE);
    tgt   = '0;
    sel_d = sel_q;
    for (int k = 0; k < dqh_pkg::NUM_LANES; k++) begin
      base[k]   = acc_q[0][k];
      factor[k] = 10'(req_i.ch) + 10'(k);
      case (req_i.op)
        dqh_pkg::HOP_CHAR: begin
          base[k] = acc_q[sel_q][k];
        end
        dqh_pkg::HOP_COMB1: begin
          factor[k] = acc_q[1][k];
        end
        dqh_pkg::HOP_COMB2: begin
          factor[k] = acc_q[2][k];
        end
        default: ;
      endcase
    end
    if (req_i.op == dqh_pkg::HOP_CHAR) begin
      tgt   = sel_q;
      sel_d = (sel_q == 2'(dqh_pkg::NUM_ACCS - 1)) ? 2'd0 : sel_q + 2'd1;
    end
  end

  // Reduction: fold the bits above 2^10 back in with 2^10 mod 829.
  always_comb begin
    logic [17:0] x1;
    logic [14:0] x2;
    logic [12:0] x3;
    logic [10:0] x4;
    for (int k = 0; k < dqh_pkg::NUM_LANES; k++) begin
      x1 = 18'(s1_prod_q[k][19:10]) * 18'(dqh_pkg::FOLD_K) + 18'(s1_prod_q[k][9:0]);
      x2 = 15'(x1[17:10]) * 15'(dqh_pkg::FOLD_K) + 15'(x1[9:0]);
      red_mid[k] = x2;
      x3 = 13'(s2_red_q[k][14:10]) * 13'(dqh_pkg::FOLD_K) + 13'(s2_red_q[k][9:0]);
      x4 = 11'(x3[12:10]) * 11'(dqh_pkg::FOLD_K) + 11'(x3[9:0]);
      if (x4 >= 11'(2 * dqh_pkg::HASH_MOD)) begin
        red_out[k] = 10'(x4 - 11'(2 * dqh_pkg::HASH_MOD));
      end else if (x4 >= 11'(dqh_pkg::HASH_MOD)) begin
        red_out[k] = 10'(x4 - 11'(dqh_pkg::HASH_MOD));
      end else begin
        red_out[k] = x4[9:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      sel_q      <= '0;
      for (int a = 0; a < dqh_pkg::NUM_ACCS; a++) begin
        for (int k = 0; k < dqh_pkg::NUM_LANES; k++) begin
          acc_q[a][k] <= 10'd1;
        end
      end
    end else if (req_i.clr) begin
      // A packet boundary flushes work in flight and restarts every lane.
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      sel_q      <= '0;
      for (int a = 0; a < dqh_pkg::NUM_ACCS; a++) begin
        for (int k = 0; k < dqh_pkg::NUM_LANES; k++) begin
          acc_q[a][k] <= 10'd1;
        end
      end
    end else begin
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      sel_q      <= sel_d;
      if (s2_valid_q) begin
        for (int k = 0; k < dqh_pkg::NUM_LANES; k++) begin
          acc_q[s2_tgt_q][k] <= red_out[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tgt_q <= tgt;
    s2_tgt_q <= s1_tgt_q;
    for (int k = 0; k < dqh_pkg::NUM_LANES; k++) begin
      s1_prod_q[k] <= 20'(base[k]) * 20'(factor[k]);
      s2_red_q[k]  <= red_mid[k];
    end
  end

  always_comb begin
    for (int k = 0; k < dqh_pkg::NUM_LANES; k++) begin
      hash_o[k] = acc_q[0][k][7:0];
    end
  end

endmodule

// ===== sv/dqh_front.sv =====
// Parser front end: accepts query bytes, tracks header and question structure,
// drives the hash unit and queues echo and answer entries. Depends on dqh_pkg.

module dqh_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  dqh_in_if.sink                              in_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output dqh_pkg::q_entry_t                   entry_o,
  output dqh_pkg::hash_req_t                  hreq_o,
  input  logic [dqh_pkg::NUM_LANES-1:0][7:0]  hash_i
);

  dqh_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] qleft_q, qleft_d;
  logic [5:0]  seg_q, seg_d;
  logic        first_q_q, first_q_d;
  logic        first_lbl_q, first_lbl_d;
  logic [2:0]  fin_cnt_q, fin_cnt_d;
  logic        fin_last_q, fin_last_d;

  logic            accept, echo, is_answer, is_bad, end_flag, fin_push, pkt_clr;
  logic [7:0]      echo_data;
  dqh_pkg::hash_op_e char_op;
  logic [7:0]      char_val;

  assign in_i.ready = (phase_q != dqh_pkg::PH_FINAL) && !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign end_flag   = !is_answer && (is_bad || in_i.in_last);
  assign fin_push   = (phase_q == dqh_pkg::PH_FINAL) && (fin_cnt_q == dqh_pkg::FIN_DONE)
                      && !q_full_i;
  assign pkt_clr    = (accept && in_i.in_last && !is_answer) || (fin_push && fin_last_q);

  // Classify the current byte against the parse phase.
  always_comb begin
    echo      = 1'b0;
    is_answer = 1'b0;
    is_bad    = 1'b0;
    echo_data = in_i.in_byte;
    char_op   = dqh_pkg::HOP_NONE;
    char_val  = in_i.in_byte;
    case (phase_q)
      dqh_pkg::PH_HEADER: begin
        echo = 1'b1;
        if (hdr_cnt_q == dqh_pkg::HDR_AN_HI) begin
          echo_data = dqh_pkg::ANCOUNT_HI;
        end else if (hdr_cnt_q == dqh_pkg::HDR_AN_LO) begin
          echo_data = dqh_pkg::ANCOUNT_LO;
        end
        is_answer = (hdr_cnt_q == dqh_pkg::HDR_LAST) && (qleft_q == '0);
      end
      dqh_pkg::PH_LEN: begin
        echo = 1'b1;
        if (in_i.in_byte > dqh_pkg::MAX_LABEL) begin
          is_bad = 1'b1;
        end else if (in_i.in_byte != '0 && first_q_q && !first_lbl_q) begin
          // Labels of the first name are joined with a dot in the hash text.
          char_op  = dqh_pkg::HOP_CHAR;
          char_val = dqh_pkg::DOT_CHAR;
        end
      end
      dqh_pkg::PH_DATA: begin
        echo = 1'b1;
        if (first_q_q) begin
          char_op = dqh_pkg::HOP_CHAR;
        end
      end
      dqh_pkg::PH_FIXED: begin
        echo      = 1'b1;
        is_answer = (seg_q == 6'd1) && (qleft_q == 16'd1);
      end
      default: ;
    endcase
  end

  // Next-state logic.
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    qleft_d     = qleft_q;
    seg_d       = seg_q;
    first_q_d   = first_q_q;
    first_lbl_d = first_lbl_q;
    fin_cnt_d   = fin_cnt_q;
    fin_last_d  = fin_last_q;
    if (accept) begin
      case (phase_q)
        dqh_pkg::PH_HEADER: begin
          if (hdr_cnt_q == dqh_pkg::HDR_QD_HI) begin
            qleft_d[15:8] = in_i.in_byte;
          end else if (hdr_cnt_q == dqh_pkg::HDR_QD_LO) begin
            qleft_d[7:0] = in_i.in_byte;
          end
          hdr_cnt_d = hdr_cnt_q + 4'd1;
          if (hdr_cnt_q == dqh_pkg::HDR_LAST) begin
            phase_d = dqh_pkg::PH_LEN;
          end
        end
        dqh_pkg::PH_LEN: begin
          if (in_i.in_byte == '0) begin
            first_q_d = 1'b0;
            seg_d     = dqh_pkg::FIXED_LEN;
            phase_d   = dqh_pkg::PH_FIXED;
          end else if (in_i.in_byte <= dqh_pkg::MAX_LABEL) begin
            if (first_q_q) begin
              first_lbl_d = 1'b0;
            end
            seg_d   = in_i.in_byte[5:0];
            phase_d = dqh_pkg::PH_DATA;
          end
        end
        dqh_pkg::PH_DATA: begin
          seg_d = seg_q - 6'd1;
          if (seg_q == 6'd1) begin
            phase_d = dqh_pkg::PH_LEN;
          end
        end
        dqh_pkg::PH_FIXED: begin
          seg_d = seg_q - 6'd1;
          if (seg_q == 6'd1) begin
            qleft_d = qleft_q - 16'd1;
            phase_d = dqh_pkg::PH_LEN;
          end
        end
        default: ;
      endcase
      if (is_answer) begin
        phase_d    = dqh_pkg::PH_FINAL;
        fin_cnt_d  = '0;
        fin_last_d = in_i.in_last;
      end else if (end_flag && !in_i.in_last) begin
        phase_d = dqh_pkg::PH_DROP;
      end
    end else if (phase_q == dqh_pkg::PH_FINAL) begin
      if (fin_cnt_q != dqh_pkg::FIN_DONE) begin
        fin_cnt_d = fin_cnt_q + 3'd1;
      end else if (fin_push) begin
        phase_d = dqh_pkg::PH_DROP;
      end
    end
    if (pkt_clr) begin
      phase_d     = dqh_pkg::PH_HEADER;
      hdr_cnt_d   = '0;
      qleft_d     = '0;
      seg_d       = '0;
      first_q_d   = 1'b1;
      first_lbl_d = 1'b1;
    end
  end

  // Output logic: queue entries and hash requests.
  always_comb begin
    push_o         = (accept && echo) || fin_push;
    entry_o.answer = fin_push;
    entry_o.data   = fin_push ? '0 : echo_data;
    entry_o.last   = !fin_push && end_flag;
    entry_o.bad    = !fin_push && end_flag;
    entry_o.hash   = hash_i;
    hreq_o.op      = accept ? char_op : dqh_pkg::HOP_NONE;
    hreq_o.ch      = char_val;
    hreq_o.clr     = pkt_clr;
    if (phase_q == dqh_pkg::PH_FINAL) begin
      // Merge the interleaved accumulators into the first one.
      if (fin_cnt_q == dqh_pkg::FIN_COMB1) begin
        hreq_o.op = dqh_pkg::HOP_COMB1;
      end else if (fin_cnt_q == dqh_pkg::FIN_COMB2) begin
        hreq_o.op = dqh_pkg::HOP_COMB2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dqh_pkg::PH_HEADER;
      hdr_cnt_q   <= '0;
      qleft_q     <= '0;
      seg_q       <= '0;
      first_q_q   <= 1'b1;
      first_lbl_q <= 1'b1;
      fin_cnt_q   <= '0;
      fin_last_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      qleft_q     <= qleft_d;
      seg_q       <= seg_d;
      first_q_q   <= first_q_d;
      first_lbl_q <= first_lbl_d;
      fin_cnt_q   <= fin_cnt_d;
      fin_last_q  <= fin_last_d;
    end
  end

endmodule

// ===== sv/dqh_queue.sv =====
// Short entry queue between the parser front end and the response back end.
// Depends on dqh_pkg for the entry type and depth.

module dqh_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dqh_pkg::q_entry_t entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output dqh_pkg::q_entry_t head_o
);

  dqh_pkg::q_entry_t                mem_q [dqh_pkg::QUEUE_DEPTH];
  logic [dqh_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [dqh_pkg::QPTR_W:0]         count_q;

  assign full_o  = (count_q == (dqh_pkg::QPTR_W + 1)'(dqh_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

// ===== sv/dqh_back.sv =====
// Response back end: turns queued entries into output bytes, expanding an answer
// entry into the 16-byte record. Depends on dqh_pkg and dqh_out_if.

module dqh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       ttl_i,
  input  logic              empty_i,
  input  dqh_pkg::q_entry_t head_i,
  output logic              pop_o,
  dqh_out_if.source         out_o
);

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q, out_bad_q;
  logic [3:0] ans_idx_q, ans_idx_d;
  logic       load;
  logic [7:0] nxt_byte;
  logic       nxt_last, nxt_bad;

  assign load = !empty_i && (!out_valid_q || out_o.ready);

  always_comb begin
    nxt_byte  = head_i.data;
    nxt_last  = head_i.last;
    nxt_bad   = head_i.bad;
    pop_o     = load;
    ans_idx_d = ans_idx_q;
    if (head_i.answer) begin
      nxt_last = (ans_idx_q == dqh_pkg::ANS_LAST);
      nxt_bad  = 1'b0;
      pop_o    = load && (ans_idx_q == dqh_pkg::ANS_LAST);
      if (load) begin
        ans_idx_d = (ans_idx_q == dqh_pkg::ANS_LAST) ? '0 : ans_idx_q + 4'd1;
      end
      case (ans_idx_q)
        4'd0:    nxt_byte = dqh_pkg::ANS_PTR_HI;
        4'd1:    nxt_byte = dqh_pkg::ANS_PTR_LO;
        4'd2:    nxt_byte = dqh_pkg::ANS_ZERO;
        4'd3:    nxt_byte = dqh_pkg::ANS_ONE;
        4'd4:    nxt_byte = dqh_pkg::ANS_ZERO;
        4'd5:    nxt_byte = dqh_pkg::ANS_ONE;
        4'd6:    nxt_byte = ttl_i[31:24];
        4'd7:    nxt_byte = ttl_i[23:16];
        4'd8:    nxt_byte = ttl_i[15:8];
        4'd9:    nxt_byte = ttl_i[7:0];
        4'd10:   nxt_byte = dqh_pkg::ANS_ZERO;
        4'd11:   nxt_byte = dqh_pkg::ANS_RDLEN;
        4'd12:   nxt_byte = head_i.hash[0];
        4'd13:   nxt_byte = head_i.hash[1];
        4'd14:   nxt_byte = head_i.hash[2];
        default: nxt_byte = head_i.hash[3];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ans_idx_q   <= '0;
    end else begin
      ans_idx_q <= ans_idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= nxt_byte;
      out_last_q <= nxt_last;
      out_bad_q  <= nxt_bad;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.out_last  = out_last_q;
  assign out_o.malformed = out_bad_q;

  a_idx_only_in_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ans_idx_q != '0 |-> !empty_i && head_i.answer)
    else $error("answer position advanced without an answer entry at the head");

  a_answer_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && head_i.answer && ans_idx_q == dqh_pkg::ANS_LAST) |=> ans_idx_q == '0)
    else $error("answer position did not return to zero after the last byte");

endmodule

// ===== sv/dns_query_hash_responder.sv =====
// DNS query hash responder, top level.
// Echoes a query byte stream as a response and appends a 16-byte A record.
// Channel in_i (sink) takes one query byte per accepted request, in_last marks the
// packet end. Channel out_o (source) gives response bytes with out_last and
// malformed on the final byte. cfg_we_i/cfg_wdata_i write the answer TTL
// (reset value 255); write it only while the block is idle.
// Path: an accepted query byte is written into the queue, then loaded into the
// output register. Throughput is one byte per cycle when the output is not stalled
// and the input is not held off; the answer record is 16 bytes. When the last
// question completes, the input is held off while the three interleaved hash
// accumulators of each lane are merged through the 3-stage multiply and reduce pipeline.
// A four-entry queue separates parser and emitter, so input keeps flowing while
// the output stalls until the queue fills, then in_i.ready drops.
// Reset clears the parser, the queue and the output register; bytes after the
// end of a response are dropped until in_last.
// Depends on dqh_pkg, dqh_in_if, dqh_out_if and the dqh_* submodules.

module dns_query_hash_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  dqh_in_if.sink      in_i,
  dqh_out_if.source   out_o
);

  logic [31:0]                          ttl_q;
  logic                                 push, pop, q_full, q_empty;
  dqh_pkg::q_entry_t                    entry, head;
  dqh_pkg::hash_req_t                   hreq;
  logic [dqh_pkg::NUM_LANES-1:0][7:0]   hash;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= 32'd255;
    end else if (cfg_we_i) begin
      ttl_q <= cfg_wdata_i;
    end
  end

  dqh_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (entry),
    .hreq_o   (hreq),
    .hash_i   (hash)
  );

  dqh_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .hash_o (hash)
  );

  dqh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  dqh_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ttl_i   (ttl_q),
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
